FILE: rtl/core/ddsl_pkg.sv
// Package for the display driver serial link master.
// Holds the item types, request codes and frame constants; depends on nothing.
`default_nettype none

package ddsl_pkg;

  localparam int unsigned KeyBytes = 4;
  localparam int unsigned KeyBits  = 8 * KeyBytes;
  localparam logic [5:0]  ReadLast = 6'(KeyBits - 1);

  localparam logic [7:0] AddrBase   = 8'(8'h03 << 6);
  localparam logic [7:0] ReadKeyCmd = 8'((8'h01 << 6) | (8'h01 << 1));
  localparam logic [3:0] AddrMask   = 4'hf;

  typedef enum logic [1:0] {
    CmdNone  = 2'd0,
    CmdSend  = 2'd1,
    CmdWrite = 2'd2,
    CmdKeys  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] command_byte;
    logic [3:0] display_address;
    logic [7:0] display_data;
    logic       dio_in;
  } in_item_t;

  typedef struct packed {
    logic        stb;
    logic        clk_res;
    logic        dio_out;
    logic        dio_drive;
    logic        busy_res;
    logic        key_valid;
    logic [31:0] key_data;
  } out_item_t;

  typedef struct packed {
    logic     valid;
    in_item_t item;
  } held_t;

endpackage

`default_nettype wire

FILE: rtl/core/ddsl_in_stage.sv
// Input register of the serial link master.
// Holds one accepted item until the frame engine takes it; uses ddsl_pkg.
`default_nettype none

module ddsl_in_stage (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  ddsl_pkg::in_item_t   in_item_i,
  input  wire                  take_i,
  output ddsl_pkg::held_t      held_o
);

  logic               valid_q;
  ddsl_pkg::in_item_t item_q;

  assign in_ready_o = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign held_o.valid = valid_q;
  assign held_o.item  = item_q;

endmodule

`default_nettype wire

FILE: rtl/core/ddsl_engine.sv
// Frame engine of the serial link master: frame state, one tick of pin
// waveform per item, and the result register. Uses ddsl_pkg.
`default_nettype none

module ddsl_engine (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  ddsl_pkg::held_t      held_i,
  output logic                 take_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output ddsl_pkg::out_item_t  out_item_o
);

  logic [1:0]  kind_q, kind_d;
  logic [5:0]  bit_q, bit_d;
  logic        phase_q, phase_d;
  logic [15:0] oshift_q, oshift_d;
  logic [31:0] ishift_q, ishift_d;
  logic        reading_q, reading_d;
  logic        closing_q, closing_d;
  logic        out_valid_q;
  ddsl_pkg::out_item_t out_q, res;

  logic        start;
  logic [1:0]  k;
  logic [5:0]  b;
  logic        ph, rd, cl;
  logic [15:0] os;
  logic [31:0] is;
  logic [5:0]  last;

  assign take_o = held_i.valid && (!out_valid_q || out_ready_i);

  always_comb begin
    start = (kind_q == ddsl_pkg::CmdNone) && (held_i.item.cmd != ddsl_pkg::CmdNone);
    k  = start ? held_i.item.cmd : kind_q;
    b  = start ? 6'd0 : bit_q;
    ph = start ? 1'b0 : phase_q;
    rd = start ? 1'b0 : reading_q;
    cl = start ? 1'b0 : closing_q;
    is = start ? 32'd0 : ishift_q;
    os = oshift_q;
    if (start) begin
      case (held_i.item.cmd)
        ddsl_pkg::CmdSend:  os = {8'd0, held_i.item.command_byte};
        ddsl_pkg::CmdWrite: os = {held_i.item.display_data,
                                  {4'd0, held_i.item.display_address & ddsl_pkg::AddrMask}
                                  | ddsl_pkg::AddrBase};
        default:            os = {8'd0, ddsl_pkg::ReadKeyCmd};
      endcase
    end
    last = (k == ddsl_pkg::CmdWrite) ? 6'd15 : 6'd7;

    kind_d    = k;
    bit_d     = b;
    phase_d   = ph;
    reading_d = rd;
    closing_d = cl;
    oshift_d  = os;
    ishift_d  = is;

    res.stb       = 1'b1;
    res.clk_res   = 1'b1;
    res.dio_out   = 1'b1;
    res.dio_drive = 1'b1;
    res.busy_res  = 1'b0;
    res.key_valid = 1'b0;
    res.key_data  = 32'd0;

    if (k != ddsl_pkg::CmdNone) begin
      res.busy_res = 1'b1;
      if (cl) begin
        if (k == ddsl_pkg::CmdKeys) begin
          res.key_valid = 1'b1;
          res.key_data  = is;
        end
        kind_d    = ddsl_pkg::CmdNone;
        closing_d = 1'b0;
        reading_d = 1'b0;
        bit_d     = 6'd0;
        phase_d   = 1'b0;
      end else begin
        res.stb = 1'b0;
        if (rd) begin
          res.dio_drive = 1'b0;
        end else begin
          res.dio_out = os[b[3:0]];
        end
        if (!ph) begin
          res.clk_res = 1'b0;
          phase_d     = 1'b1;
        end else begin
          phase_d = 1'b0;
          if (rd) begin
            if (!b[5]) begin
              ishift_d[b[4:0]] = is[b[4:0]] | held_i.item.dio_in;
            end
            if (b >= ddsl_pkg::ReadLast) begin
              closing_d = 1'b1;
            end else begin
              bit_d = b + 6'd1;
            end
          end else if (b >= last) begin
            bit_d = 6'd0;
            if (k == ddsl_pkg::CmdKeys) begin
              reading_d = 1'b1;
            end else begin
              closing_d = 1'b1;
            end
          end else begin
            bit_d = b + 6'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q      <= ddsl_pkg::CmdNone;
      bit_q       <= 6'd0;
      phase_q     <= 1'b0;
      reading_q   <= 1'b0;
      closing_q   <= 1'b0;
      oshift_q    <= 16'd0;
      ishift_q    <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (take_o) begin
        kind_q    <= kind_d;
        bit_q     <= bit_d;
        phase_q   <= phase_d;
        reading_q <= reading_d;
        closing_q <= closing_d;
        oshift_q  <= oshift_d;
        ishift_q  <= ishift_d;
      end
      if (take_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

FILE: rtl/core/display_driver_serial_link.sv
// Top level of the display driver serial link master.
// Joins the input register and the frame engine; uses ddsl_pkg.
//
//   Channel   Signals                                Carries
//   in        in_valid_i, in_ready_o, in_item_i      one tick with optional request
//   out       out_valid_o, out_ready_i, out_item_o   pin levels and key data of that tick
//
// One item is taken every cycle when the result side keeps up.
// An item accepted into the input register enters the result register when the engine takes it.
// The frame state advances only when an item moves into the result register.
// Reset returns the link to idle with no item held on either side.
// A stall on the output holds the result and fills the input register, then
// drops in_ready_o.
`default_nettype none

module display_driver_serial_link (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  ddsl_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output ddsl_pkg::out_item_t  out_item_o
);

  ddsl_pkg::held_t held;
  logic            take;

  ddsl_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .take_i     (take),
    .held_o     (held)
  );

  ddsl_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .held_i      (held),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

FILE: rtl/core/ddsl_checker.sv
// Port checker for the display driver serial link master, bound to the top.
// Uses ddsl_pkg for the result item type.
`default_nettype none

module ddsl_checker (
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 out_valid_o,
  input wire                 out_ready_i,
  input ddsl_pkg::out_item_t out_item_o
);

  a_key_on_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.key_valid |->
      out_item_o.busy_res && out_item_o.stb && out_item_o.clk_res && out_item_o.dio_drive)
    else $error("key data shown outside a closing tick");

  a_key_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.key_valid |-> out_item_o.key_data == 32'd0)
    else $error("key data not zero without key valid");

  a_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.dio_drive |->
      out_item_o.dio_out && !out_item_o.stb && out_item_o.busy_res)
    else $error("data line released outside a key read");

  a_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.busy_res |->
      out_item_o.stb && out_item_o.clk_res && out_item_o.dio_out && out_item_o.dio_drive)
    else $error("pins not idle while link is idle");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result item changed");

endmodule

bind display_driver_serial_link ddsl_checker u_ddsl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire

FILE: verif/tb.sv
// Testbench for the display driver serial link master.
// Checks every tick's pin levels and key data against a behavioral model of the link.
// Depends on ddsl_pkg and display_driver_serial_link.
`timescale 1ns / 100ps

module tb;
  import ddsl_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 8;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      out_ready_i = 1'b0;
  in_item_t  in_item_i   = '0;
  logic      in_ready_o;
  logic      out_valid_o;
  out_item_t out_item_o;

  display_driver_serial_link u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always #1 clk_i = ~clk_i;

  // Model state of the link, at its reset values.
  logic [1:0]  frame_kind  = CmdNone;
  logic [5:0]  bit_pos     = '0;
  logic        high_phase  = 1'b0;
  logic [15:0] tx_shift    = '0;
  logic [31:0] key_shift   = '0;
  logic        reading     = 1'b0;
  logic        closing     = 1'b0;

  out_item_t pin_levels_q[$];
  int unsigned mismatches  = 0;
  int unsigned ticks_sent  = 0;
  int unsigned ticks_seen  = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_req      = 0;
  int unsigned hold_left     = 0;

  function automatic out_item_t link_tick(in_item_t it);
    out_item_t  res;
    logic [5:0] last;
    res = '{stb: 1'b1, clk_res: 1'b1, dio_out: 1'b1, dio_drive: 1'b1,
            busy_res: 1'b0, key_valid: 1'b0, key_data: 32'h0};
    if (frame_kind == CmdNone && it.cmd != CmdNone) begin
      frame_kind = it.cmd;
      bit_pos    = '0;
      high_phase = 1'b0;
      key_shift  = '0;
      reading    = 1'b0;
      closing    = 1'b0;
      case (it.cmd)
        CmdSend:  tx_shift = {8'h00, it.command_byte};
        CmdWrite: tx_shift = {it.display_data, 4'h0 | AddrBase | (it.display_address & AddrMask)};
        default:  tx_shift = {8'h00, ReadKeyCmd};
      endcase
    end
    if (frame_kind != CmdNone) begin
      res.busy_res = 1'b1;
      if (closing) begin
        if (frame_kind == CmdKeys) begin
          res.key_valid = 1'b1;
          res.key_data  = key_shift;
        end
        frame_kind = CmdNone;
        closing    = 1'b0;
        reading    = 1'b0;
        bit_pos    = '0;
        high_phase = 1'b0;
      end else begin
        res.stb = 1'b0;
        if (reading) begin
          res.dio_drive = 1'b0;
        end else begin
          res.dio_out = tx_shift[bit_pos[3:0]];
        end
        if (!high_phase) begin
          res.clk_res = 1'b0;
          high_phase  = 1'b1;
        end else begin
          high_phase = 1'b0;
          if (reading) begin
            if (bit_pos < 6'd32 && it.dio_in) key_shift[bit_pos[4:0]] = 1'b1;
            if (bit_pos >= ReadLast) closing = 1'b1;
            else bit_pos = bit_pos + 6'd1;
          end else begin
            last = (frame_kind == CmdWrite) ? 6'd15 : 6'd7;
            if (bit_pos >= last) begin
              bit_pos = '0;
              if (frame_kind == CmdKeys) reading = 1'b1;
              else closing = 1'b1;
            end else begin
              bit_pos = bit_pos + 6'd1;
            end
          end
        end
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
    mismatches++;
    if (mismatches <= 40) begin
      $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, exp);
    end
  endtask

  task automatic check_item(out_item_t got, out_item_t exp);
    if (got.stb !== exp.stb) begin
      report_mismatch("stb", 32'(got.stb), 32'(exp.stb));
    end
    if (got.clk_res !== exp.clk_res) begin
      report_mismatch("clk_res", 32'(got.clk_res), 32'(exp.clk_res));
    end
    if (got.dio_out !== exp.dio_out) begin
      report_mismatch("dio_out", 32'(got.dio_out), 32'(exp.dio_out));
    end
    if (got.dio_drive !== exp.dio_drive) begin
      report_mismatch("dio_drive", 32'(got.dio_drive), 32'(exp.dio_drive));
    end
    if (got.busy_res !== exp.busy_res) begin
      report_mismatch("busy_res", 32'(got.busy_res), 32'(exp.busy_res));
    end
    if (got.key_valid !== exp.key_valid) begin
      report_mismatch("key_valid", 32'(got.key_valid), 32'(exp.key_valid));
    end
    if (got.key_data !== exp.key_data) report_mismatch("key_data", got.key_data, exp.key_data);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pin_levels_q.size() == 0) begin
          report_mismatch("unexpected item", out_item_o.key_data, 32'h0);
        end else begin
          check_item(out_item_o, pin_levels_q.pop_front());
        end
        ticks_seen++;
      end
      if (in_valid_i && in_ready_o) begin
        pin_levels_q.push_back(link_tick(in_item_i));
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("display_driver_serial_link regression: fail");
    $finish;
  end

  task automatic send_tick(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    ticks_sent++;
  endtask

  task automatic tick(logic [1:0] cmd, logic [7:0] cbyte, logic [3:0] addr,
                      logic [7:0] data, logic din);
    in_item_t it;
    it = '{cmd: cmd, command_byte: cbyte, display_address: addr,
           display_data: data, dio_in: din};
    send_tick(it);
  endtask

  task automatic idle_ticks(int unsigned n, logic random_din);
    repeat (n) begin
      tick(CmdNone, 8'($urandom), 4'($urandom), 8'($urandom),
           random_din ? 1'($urandom) : 1'b1);
    end
  endtask

  task automatic wait_results();
    in_valid_i <= 1'b0;
    while (ticks_seen < ticks_sent) @(posedge clk_i);
  endtask

  function automatic in_item_t random_tick();
    in_item_t    it;
    int unsigned pick;
    it   = in_item_t'({$urandom, $urandom});
    pick = $urandom_range(9);
    if (pick < 4) it.cmd = CmdNone;
    else if (pick < 6) it.cmd = CmdSend;
    else if (pick < 8) it.cmd = CmdWrite;
    else it.cmd = CmdKeys;
    return it;
  endfunction

  task automatic test_directed();
    send_idle_pct = 0;
    stall_pct     = 0;
    tick(CmdSend, 8'hff, 4'h0, 8'h00, 1'b0);
    idle_ticks(4, 1'b1);
    tick(CmdWrite, 8'h00, 4'hf, 8'hff, 1'b0);
    idle_ticks(10, 1'b1);
    tick(CmdKeys, 8'h00, 4'h0, 8'h00, 1'b0);
    tick(CmdSend, 8'h00, 4'h0, 8'h00, 1'b0);
    idle_ticks(15, 1'b1);
    tick(CmdWrite, 8'h00, 4'hf, 8'ha5, 1'b0);
    idle_ticks(32, 1'b1);
    tick(CmdWrite, 8'hff, 4'h0, 8'h5a, 1'b1);
    idle_ticks(33, 1'b1);
    tick(CmdKeys, 8'hff, 4'hf, 8'hff, 1'b1);
    idle_ticks(80, 1'b0);
    tick(CmdKeys, 8'h00, 4'h0, 8'h00, 1'b0);
    idle_ticks(81, 1'b1);
    wait_results();
  endtask

  task automatic test_random(int unsigned idle_pct, int unsigned stall, int unsigned n);
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    repeat (n) send_tick(random_tick());
    wait_results();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = 80;
    repeat (40) send_tick(random_tick());
    wait_results();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(0, 0, 60);
    test_random(82, 0, 60);
    test_random(0, 82, 60);
    test_random(37, 37, 60);
    test_backpressure();
    wait_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (pin_levels_q.size() != 0) begin
      report_mismatch("items never returned", pin_levels_q.size(), 32'h0);
    end
    if (mismatches == 0) begin
      $display("display_driver_serial_link regression: pass");
    end else begin
      $display("display_driver_serial_link regression: fail");
    end
    $finish;
  end

endmodule
